FILE: design/lcdt_pkg.sv
// Shared types, timing constants and register indexes for the LCD scanline mode timer.
package lcdt_pkg;

   // Line timing in dots and lines
   localparam logic [9:0] DOTS_OAM_END      = 10'd80;
   localparam logic [9:0] DOTS_XFER_END     = 10'd252;
   localparam logic [9:0] DOTS_PER_LINE     = 10'd456;
   localparam logic [7:0] LAST_LINE         = 8'd153;
   localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;

   // Configuration register indexes
   localparam logic [2:0] CSR_DISPLAY_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_COMPARE_LINE      = 3'd1;
   localparam logic [2:0] CSR_COMPARE_ENABLE    = 3'd2;
   localparam logic [2:0] CSR_HBLANK_IRQ_ENABLE = 3'd3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef struct packed {
      logic       display_enable;
      logic [7:0] compare_line;
      logic       compare_enable;
      logic       hblank_irq_enable;
   } cfg_type;

   typedef struct packed {
      logic [9:0] dot_count;
      logic [7:0] line_count;
      logic       coincidence;
      mode_type   mode;
   } state_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] current_line;
      logic       coincidence;
      logic       oam_accessible;
      logic       vram_accessible;
      logic       line_done;
      logic       status_irq;
      logic       vblank_irq;
   } result_type;

endpackage

FILE: design/lcd_scanline_mode_timer.sv
// LCD scanline mode timer: top level with timing state, config and output register.
// Each request word carries the elapsed time since the previous word; the block
// adds it to the line dot counter, picks the display mode and access flags, and
// advances the line and pulses interrupts at line ends. Unless stalled, one word is
// accepted per cycle; its response is valid on the next cycle: the update is one add
// and a few compares feeding the response register; req_stall follows rsp_stall only
// while a response is held. The user keeps configuration writes to idle; unenforced.
module lcd_scanline_mode_timer import lcdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_clocks_elapsed,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_mode,
   output logic [7:0] rsp_current_line,
   output logic       rsp_coincidence,
   output logic       rsp_oam_accessible,
   output logic       rsp_vram_accessible,
   output logic       rsp_line_done,
   output logic       rsp_status_irq,
   output logic       rsp_vblank_irq,
   // configuration write port
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISPLAY_ENABLE:    cfg_in.display_enable    = csr_wdata[0];
            CSR_COMPARE_LINE:      cfg_in.compare_line      = csr_wdata;
            CSR_COMPARE_ENABLE:    cfg_in.compare_enable    = csr_wdata[0];
            CSR_HBLANK_IRQ_ENABLE: cfg_in.hblank_irq_enable = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enable    <= 1'b1;
         cfg_ff.compare_line      <= 8'd0;
         cfg_ff.compare_enable    <= 1'b0;
         cfg_ff.hblank_irq_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdt_step u_step (
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .clocks_elapsed (req_clocks_elapsed),
      .state_nxt      (state_in),
      .result         (result_in)
   );

   // timing state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.dot_count   <= 10'd0;
         state_ff.line_count  <= 8'd0;
         state_ff.coincidence <= 1'b0;
         state_ff.mode        <= MODE_HBLANK;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (!req_stall) begin
            rsp_valid_ff <= req_valid;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = result_ff.mode;
   assign rsp_current_line    = result_ff.current_line;
   assign rsp_coincidence     = result_ff.coincidence;
   assign rsp_oam_accessible  = result_ff.oam_accessible;
   assign rsp_vram_accessible = result_ff.vram_accessible;
   assign rsp_line_done       = result_ff.line_done;
   assign rsp_status_irq      = result_ff.status_irq;
   assign rsp_vblank_irq      = result_ff.vblank_irq;

   // checks
   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.dot_count < DOTS_PER_LINE)
      else $error("dot counter out of range");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.line_count <= LAST_LINE)
      else $error("line counter out of range");

   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |->
         rsp_current_line == FIRST_VBLANK_LINE && rsp_mode == MODE_VBLANK && rsp_line_done)
      else $error("vblank pulse without entry to first vblank line");

   a_irq_on_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_irq |-> rsp_line_done)
      else $error("status interrupt outside a line end");

   a_state_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && rsp_current_line == state_ff.line_count
                 && rsp_mode == state_ff.mode)
      else $error("response does not match updated state");

endmodule

FILE: design/lcdt_step.sv
// Next-state and result logic for one elapsed-clocks word.
module lcdt_step import lcdt_pkg::*; (
   input  state_type  state_cur,
   input  cfg_type    cfg,
   input  logic [7:0] clocks_elapsed,
   output state_type  state_nxt,
   output result_type result
);

   logic [9:0] dots;
   logic [7:0] line_inc;
   logic       visible;

   // dot_count stays below 456, so the sum fits in 10 bits
   assign dots     = state_cur.dot_count + {2'b00, clocks_elapsed};
   assign line_inc = (state_cur.line_count == LAST_LINE) ? 8'd0
                                                         : state_cur.line_count + 8'd1;
   assign visible  = state_cur.line_count < FIRST_VBLANK_LINE;

   always_comb begin
      state_nxt         = state_cur;
      result.line_done  = 1'b0;
      result.status_irq = 1'b0;
      result.vblank_irq = 1'b0;

      if (visible) begin
         priority if (dots < DOTS_OAM_END) begin
            state_nxt.mode      = MODE_OAM;
            state_nxt.dot_count = dots;
         end else if (dots < DOTS_XFER_END) begin
            state_nxt.mode      = MODE_XFER;
            state_nxt.dot_count = dots;
         end else if (dots < DOTS_PER_LINE) begin
            state_nxt.mode      = MODE_HBLANK;
            state_nxt.dot_count = dots;
         end else begin
            // line end: mode held unless entering vblank
            state_nxt.dot_count = 10'd0;
            result.line_done    = 1'b1;
            if (cfg.display_enable) begin
               state_nxt.coincidence = cfg.compare_enable &&
                                       (state_cur.line_count == cfg.compare_line);
               result.status_irq     = cfg.hblank_irq_enable;
               state_nxt.line_count  = line_inc;
               if (line_inc == FIRST_VBLANK_LINE) begin
                  result.vblank_irq = 1'b1;
                  state_nxt.mode    = MODE_VBLANK;
               end
            end
         end
      end else begin
         // vblank lines advance whatever the enable, no interrupts
         if (dots >= DOTS_PER_LINE) begin
            state_nxt.dot_count  = 10'd0;
            result.line_done     = 1'b1;
            state_nxt.line_count = line_inc;
         end else begin
            state_nxt.dot_count = dots;
         end
      end

      // access flags follow the resulting mode on visible lines
      result.oam_accessible  = 1'b1;
      result.vram_accessible = 1'b1;
      if (visible) begin
         unique case (state_nxt.mode)
            MODE_OAM: begin
               result.oam_accessible  = 1'b0;
               result.vram_accessible = 1'b1;
            end
            MODE_XFER: begin
               result.oam_accessible  = 1'b0;
               result.vram_accessible = 1'b0;
            end
            default: begin
               result.oam_accessible  = 1'b1;
               result.vram_accessible = 1'b1;
            end
         endcase
      end

      result.mode         = state_nxt.mode;
      result.current_line = state_nxt.line_count;
      result.coincidence  = state_nxt.coincidence;
   end

endmodule
